// ===== rtl/owaf_pkg.sv =====
// shared constants, status codes and sequencer states of the anova f statistic unit
package owaf_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int MAX_GROUPS  = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int GIDX_W      = $clog2(MAX_GROUPS);
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 38;
  localparam int MEAN_W      = 41;
  localparam int DEV_W       = 42;
  localparam int WIDE_W      = 128;
  localparam int MPL_W       = 48;
  localparam int QUO_W       = 64;
  localparam int ENTRY_W     = 36;

  localparam logic [31:0] F_FLAT   = 32'd6553600;
  localparam logic [4:0]  GT_MIN   = 5'd2;
  localparam logic [4:0]  GT_MAX   = 5'd16;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FLAT  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MEAN_SET,
    ST_MEAN_DIV,
    ST_MEAN_WR,
    ST_GRAND_SET,
    ST_GRAND_DIV,
    ST_GRAND_WR,
    ST_SSB_SET,
    ST_SSB_SQ,
    ST_SSB_MUL,
    ST_SSW_SET,
    ST_SSW_WAIT,
    ST_SSW_SQ,
    ST_FIN_CHK,
    ST_NUM_MUL,
    ST_DEN_MUL,
    ST_FDIV,
    ST_FDIV_END,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/owaf_in_if.sv =====
// input channel: one sample item with its group and end-of-row flag
interface owaf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic        [3:0]  group;
  logic               last;

  modport source (output valid, sample, group, last, input ready);
  modport sink   (input valid, sample, group, last, output ready);
endinterface

// ===== rtl/owaf_out_if.sv =====
// result channel: f statistic and status item
interface owaf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] f_value;
  logic [1:0]  status;

  modport source (output valid, f_value, status, input ready);
  modport sink   (input valid, f_value, status, output ready);
endinterface

// ===== rtl/owaf_ram.sv =====
// generic single write port ram with registered read
module owaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/one_way_anova_f_statistic_unit.sv =====
// top level of the one-way anova f statistic unit
//
// channel   | dir | handshake          | payload
// in_ch     | in  | valid/ready        | sample (s32 q16.16), group (u4), last (u1)
// out_ch    | out | valid/ready        | f_value (u32 q16.16), status (u2)
// cfg       | in  | cfg_we, no wait    | cfg_wdata = group_total (u5)
//
// a sample item is taken while idle; the item with last set starts the row pass, ready low
// row pass: a divide per group mean, one for the grand mean, a square and a multiply per
// group for the between-group term, a square per stored sample of a group in use, then
// the final multiplies and the 128-step divide, on one shift-add multiplier and one divider
// reset clears accumulators and row count and sets group_total to 2
// a stalled out_ch holds its item while the next row loads; that row's result then waits
module one_way_anova_f_statistic_unit
  import owaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  owaf_in_if.sink    in_ch,
  owaf_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [4:0]              gt_r;
  logic signed [SUM_W-1:0] gsum_r   [MAX_GROUPS];
  logic signed [SUM_W-1:0] gsum_nxt [MAX_GROUPS];
  logic [CNT_W-1:0]        gsize_r  [MAX_GROUPS];
  logic [CNT_W-1:0]        gsize_nxt[MAX_GROUPS];
  logic signed [MEAN_W-1:0] mean_r  [MAX_GROUPS];
  logic signed [MEAN_W-1:0] mean_nxt[MAX_GROUPS];
  logic [CNT_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        nall_r, nall_nxt;
  logic signed [SUM_W-1:0] total_r, total_nxt;
  logic signed [MEAN_W-1:0] grand_r, grand_nxt;

  logic [WIDE_W-1:0] macc_r, macc_nxt, mcand_r, mcand_nxt;
  logic [MPL_W-1:0]  mplier_r, mplier_nxt;
  logic [WIDE_W-1:0] dnum_r, dnum_nxt, dden_r, dden_nxt, drem_r, drem_nxt;
  logic [QUO_W-1:0]  dquo_r, dquo_nxt;
  logic              dovf_r, dovf_nxt, dneg_r, dneg_nxt;
  logic [7:0]        dcnt_r, dcnt_nxt;
  logic [WIDE_W-1:0] ssb_r, ssb_nxt, ssw_r, ssw_nxt, tmp_r, tmp_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] f_r, f_nxt, out_f_r, out_f_nxt;
  logic [1:0]  st_r, st_nxt, out_st_r, out_st_nxt;

  logic                    in_acc, out_load, mul_done, div_done, div_ge;
  logic [GIDX_W-1:0]       g_idx, mean_addr;
  logic [WIDE_W:0]         rem_sh, rem_new;
  logic [WIDE_W-1:0]       macc_step;
  logic signed [MEAN_W-1:0] q_s, cur_mean;
  logic signed [SUM_W+7:0] sum_x, tot_x;
  logic [SUM_W+7:0]        sum_mag, tot_mag;
  logic signed [DEV_W-1:0] dev_b, dev_w;
  logic [DEV_W-1:0]        dev_b_mag, dev_w_mag;
  logic                    ram_we;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [3:0]              rd_tag;
  logic signed [31:0]      rd_sample;
  logic [4:0]              cfg_clamped;
  logic                    g_end, tag_ok;

  owaf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_cnt_r[ADDR_W-1:0]),
    .wdata ({in_ch.group, in_ch.sample}),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.f_value = out_f_r;
  assign out_ch.status  = out_st_r;

  assign g_idx     = idx_r[GIDX_W-1:0];
  assign g_end     = (idx_r == {2'b00, gt_r});
  assign rd_tag    = ram_rdata[ENTRY_W-1:32];
  assign rd_sample = $signed(ram_rdata[31:0]);
  assign tag_ok    = ({1'b0, rd_tag} < gt_r);
  assign mean_addr = (state_r == ST_SSW_WAIT) ? rd_tag : g_idx;
  assign cur_mean  = mean_r[mean_addr];

  assign cfg_clamped = (cfg_wdata < GT_MIN) ? GT_MIN :
                       (cfg_wdata > GT_MAX) ? GT_MAX : cfg_wdata;

  // shared shift-add multiplier
  assign macc_step = mplier_r[0] ? (macc_r + mcand_r) : macc_r;
  assign mul_done  = (mplier_r[MPL_W-1:1] == '0);

  // shared restoring divider
  assign rem_sh   = {drem_r, dnum_r[WIDE_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, dden_r});
  assign rem_new  = div_ge ? (rem_sh - {1'b0, dden_r}) : rem_sh;
  assign div_done = (dcnt_r == 8'd1);
  assign q_s      = dneg_r ? -$signed(dquo_r[MEAN_W-1:0]) : $signed(dquo_r[MEAN_W-1:0]);

  assign sum_x   = {gsum_r[g_idx], 8'b0};
  assign sum_mag = sum_x[SUM_W+7] ? 46'(-sum_x) : 46'(sum_x);
  assign tot_x   = {total_r, 8'b0};
  assign tot_mag = tot_x[SUM_W+7] ? 46'(-tot_x) : 46'(tot_x);

  assign dev_b     = DEV_W'(cur_mean) - DEV_W'(grand_r);
  assign dev_b_mag = dev_b[DEV_W-1] ? DEV_W'(-dev_b) : DEV_W'(dev_b);
  assign dev_w     = DEV_W'($signed({rd_sample, 8'b0})) - DEV_W'(cur_mean);
  assign dev_w_mag = dev_w[DEV_W-1] ? DEV_W'(-dev_w) : DEV_W'(dev_w);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_acc && in_ch.last) state_nxt = ST_MEAN_SET;
      ST_MEAN_SET: begin
        if (g_end) state_nxt = ST_GRAND_SET;
        else if (gsize_r[g_idx] == '0) state_nxt = ST_OUT;
        else state_nxt = ST_MEAN_DIV;
      end
      ST_MEAN_DIV:  if (div_done) state_nxt = ST_MEAN_WR;
      ST_MEAN_WR:   state_nxt = ST_MEAN_SET;
      ST_GRAND_SET: state_nxt = (nall_r <= {2'b00, gt_r}) ? ST_OUT : ST_GRAND_DIV;
      ST_GRAND_DIV: if (div_done) state_nxt = ST_GRAND_WR;
      ST_GRAND_WR:  state_nxt = ST_SSB_SET;
      ST_SSB_SET:   state_nxt = g_end ? ST_SSW_SET : ST_SSB_SQ;
      ST_SSB_SQ:    if (mul_done) state_nxt = ST_SSB_MUL;
      ST_SSB_MUL:   if (mul_done) state_nxt = ST_SSB_SET;
      ST_SSW_SET:   state_nxt = (idx_r == row_cnt_r) ? ST_FIN_CHK : ST_SSW_WAIT;
      ST_SSW_WAIT:  state_nxt = tag_ok ? ST_SSW_SQ : ST_SSW_SET;
      ST_SSW_SQ:    if (mul_done) state_nxt = ST_SSW_SET;
      ST_FIN_CHK:   state_nxt = (ssw_r == '0) ? ST_OUT : ST_NUM_MUL;
      ST_NUM_MUL:   if (mul_done) state_nxt = ST_DEN_MUL;
      ST_DEN_MUL:   if (mul_done) state_nxt = ST_FDIV;
      ST_FDIV:      if (div_done) state_nxt = ST_FDIV_END;
      ST_FDIV_END:  state_nxt = ST_OUT;
      ST_OUT:       if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    gsum_nxt    = gsum_r;
    gsize_nxt   = gsize_r;
    mean_nxt    = mean_r;
    row_cnt_nxt = row_cnt_r;
    idx_nxt     = idx_r;
    nall_nxt    = nall_r;
    total_nxt   = total_r;
    grand_nxt   = grand_r;
    macc_nxt    = macc_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    dnum_nxt    = dnum_r;
    dden_nxt    = dden_r;
    drem_nxt    = drem_r;
    dquo_nxt    = dquo_r;
    dovf_nxt    = dovf_r;
    dneg_nxt    = dneg_r;
    dcnt_nxt    = dcnt_r;
    ssb_nxt     = ssb_r;
    ssw_nxt     = ssw_r;
    tmp_nxt     = tmp_r;
    f_nxt       = f_r;
    st_nxt      = st_r;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    out_f_nxt   = out_f_r;
    out_st_nxt  = out_st_r;

    // common step of the shared units
    if (state_r == ST_SSB_SQ || state_r == ST_SSB_MUL || state_r == ST_SSW_SQ ||
        state_r == ST_NUM_MUL || state_r == ST_DEN_MUL) begin
      macc_nxt   = macc_step;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
    end
    if (state_r == ST_MEAN_DIV || state_r == ST_GRAND_DIV || state_r == ST_FDIV) begin
      dnum_nxt = dnum_r << 1;
      drem_nxt = rem_new[WIDE_W-1:0];
      dquo_nxt = {dquo_r[QUO_W-2:0], div_ge};
      dovf_nxt = dovf_r | dquo_r[QUO_W-1];
      dcnt_nxt = dcnt_r - 8'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (row_cnt_r < CNT_W'(MAX_SAMPLES)) begin
            ram_we                = 1'b1;
            gsum_nxt[in_ch.group] = gsum_r[in_ch.group] + SUM_W'(in_ch.sample);
            gsize_nxt[in_ch.group] = gsize_r[in_ch.group] + 1'b1;
            row_cnt_nxt           = row_cnt_r + 1'b1;
          end
          idx_nxt   = '0;
          nall_nxt  = '0;
          total_nxt = '0;
          ssb_nxt   = '0;
          ssw_nxt   = '0;
        end
      end
      ST_MEAN_SET: begin
        if (!g_end) begin
          if (gsize_r[g_idx] == '0) begin
            f_nxt  = '0;
            st_nxt = STATUS_EMPTY;
          end else begin
            nall_nxt  = nall_r + gsize_r[g_idx];
            total_nxt = total_r + gsum_r[g_idx];
            dnum_nxt  = {sum_mag, 82'b0};
            dden_nxt  = WIDE_W'(gsize_r[g_idx]);
            drem_nxt  = '0;
            dquo_nxt  = '0;
            dovf_nxt  = 1'b0;
            dneg_nxt  = sum_x[SUM_W+7];
            dcnt_nxt  = 8'(SUM_W + 8);
          end
        end else begin
          idx_nxt = '0;
        end
      end
      ST_MEAN_WR: begin
        mean_nxt[g_idx] = q_s;
        idx_nxt         = idx_r + 1'b1;
      end
      ST_GRAND_SET: begin
        if (nall_r <= {2'b00, gt_r}) begin
          f_nxt  = '0;
          st_nxt = STATUS_EMPTY;
        end else begin
          dnum_nxt = {tot_mag, 82'b0};
          dden_nxt = WIDE_W'(nall_r);
          drem_nxt = '0;
          dquo_nxt = '0;
          dovf_nxt = 1'b0;
          dneg_nxt = tot_x[SUM_W+7];
          dcnt_nxt = 8'(SUM_W + 8);
        end
      end
      ST_GRAND_WR: begin
        grand_nxt = q_s;
        idx_nxt   = '0;
      end
      ST_SSB_SET: begin
        if (g_end) begin
          idx_nxt = '0;
        end else begin
          macc_nxt   = '0;
          mcand_nxt  = WIDE_W'(dev_b_mag);
          mplier_nxt = MPL_W'(dev_b_mag);
        end
      end
      ST_SSB_SQ: begin
        if (mul_done) begin
          macc_nxt   = '0;
          mcand_nxt  = macc_step;
          mplier_nxt = MPL_W'(gsize_r[g_idx]);
        end
      end
      ST_SSB_MUL: begin
        if (mul_done) begin
          ssb_nxt = ssb_r + macc_step;
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SSW_SET: begin
      end
      ST_SSW_WAIT: begin
        if (tag_ok) begin
          macc_nxt   = '0;
          mcand_nxt  = WIDE_W'(dev_w_mag);
          mplier_nxt = MPL_W'(dev_w_mag);
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SSW_SQ: begin
        if (mul_done) begin
          ssw_nxt = ssw_r + macc_step;
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIN_CHK: begin
        if (ssw_r == '0) begin
          f_nxt  = F_FLAT;
          st_nxt = STATUS_FLAT;
        end else begin
          macc_nxt   = '0;
          mcand_nxt  = ssb_r;
          mplier_nxt = MPL_W'(nall_r - CNT_W'(gt_r));
        end
      end
      ST_NUM_MUL: begin
        if (mul_done) begin
          tmp_nxt    = macc_step << 16;
          macc_nxt   = '0;
          mcand_nxt  = ssw_r;
          mplier_nxt = MPL_W'(gt_r - 5'd1);
        end
      end
      ST_DEN_MUL: begin
        if (mul_done) begin
          dnum_nxt = tmp_r;
          dden_nxt = macc_step;
          drem_nxt = '0;
          dquo_nxt = '0;
          dovf_nxt = 1'b0;
          dneg_nxt = 1'b0;
          dcnt_nxt = 8'(WIDE_W);
        end
      end
      ST_FDIV_END: begin
        f_nxt  = (dovf_r || (dquo_r[QUO_W-1:32] != '0)) ? '1 : dquo_r[31:0];
        st_nxt = STATUS_OK;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load    = 1'b1;
          out_f_nxt   = f_r;
          out_st_nxt  = st_r;
          row_cnt_nxt = '0;
          for (int i = 0; i < MAX_GROUPS; i++) begin
            gsum_nxt[i]  = '0;
            gsize_nxt[i] = '0;
          end
        end
      end
      default: begin
      end
    endcase

    if (out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gt_r        <= GT_MIN;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        gsum_r[i]  <= '0;
        gsize_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      gsum_r      <= gsum_nxt;
      gsize_r     <= gsize_nxt;
      if (cfg_we) begin
        gt_r <= cfg_clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    mean_r   <= mean_nxt;
    idx_r    <= idx_nxt;
    nall_r   <= nall_nxt;
    total_r  <= total_nxt;
    grand_r  <= grand_nxt;
    macc_r   <= macc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    dnum_r   <= dnum_nxt;
    dden_r   <= dden_nxt;
    drem_r   <= drem_nxt;
    dquo_r   <= dquo_nxt;
    dovf_r   <= dovf_nxt;
    dneg_r   <= dneg_nxt;
    dcnt_r   <= dcnt_nxt;
    ssb_r    <= ssb_nxt;
    ssw_r    <= ssw_nxt;
    tmp_r    <= tmp_nxt;
    f_r      <= f_nxt;
    st_r     <= st_nxt;
    out_f_r  <= out_f_nxt;
    out_st_r <= out_st_nxt;
  end

endmodule

// ===== rtl/owaf_chk.sv =====
// port checker for the anova f statistic unit and its bind
module owaf_chk
  import owaf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_f_value,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("item taken during row pass");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_flat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FLAT |-> out_f_value == F_FLAT)
    else $error("flat row without f of 100");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EMPTY |-> out_f_value == '0)
    else $error("empty row with nonzero f");

endmodule

bind one_way_anova_f_statistic_unit owaf_chk u_owaf_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_f_value (out_ch.f_value),
  .out_status  (out_ch.status)
);

// ===== sim/owaf_tb_if.sv =====
// the testbench uses the channel interfaces of the rtl folder as they are

// ===== sim/testbench.sv =====
// testbench of the anova f statistic unit: row stimulus, f prediction and result checks
module testbench;
  import owaf_pkg::*;

  typedef struct packed {
    logic [31:0] f_value;
    logic [1:0]  status;
  } f_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  owaf_in_if  in_ch();
  owaf_out_if out_ch();

  one_way_anova_f_statistic_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic signed [31:0] row_samples[MAX_SAMPLES];
  logic [3:0]         row_tags[MAX_SAMPLES];
  int                 row_len;
  int                 groups_in_use;
  f_result_t          f_expected[$];

  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  longint cycles = 0;
  int  hold_cycles = 0;

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd12000000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [127:0] square_mag(input logic signed [63:0] d);
    logic [63:0] m;
    m = d < 0 ? -d : d;
    return 128'(m) * 128'(m);
  endfunction

  function automatic f_result_t anova_f(input int p);
    logic signed [63:0] gsum[MAX_GROUPS];
    int                 gsize[MAX_GROUPS];
    logic signed [63:0] mean[MAX_GROUPS];
    logic signed [63:0] total, grand;
    logic [127:0] ssb, ssw, num, den, q;
    int n_all;
    f_result_t r;
    r.f_value = '0;
    r.status = STATUS_EMPTY;
    total = 0;
    n_all = 0;
    ssb = '0;
    ssw = '0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      gsum[g] = 0;
      gsize[g] = 0;
    end
    for (int i = 0; i < row_len; i++) begin
      gsum[row_tags[i]] += 64'(row_samples[i]);
      gsize[row_tags[i]]++;
    end
    for (int g = 0; g < p; g++) begin
      if (gsize[g] == 0) return r;
      n_all += gsize[g];
      total += gsum[g];
      mean[g] = (gsum[g] * 256) / 64'(gsize[g]);
    end
    if (n_all <= p) return r;
    grand = (total * 256) / 64'(n_all);
    for (int g = 0; g < p; g++)
      ssb += square_mag(mean[g] - grand) * 128'(gsize[g]);
    for (int i = 0; i < row_len; i++)
      if (row_tags[i] < p)
        ssw += square_mag(64'(row_samples[i]) * 256 - mean[row_tags[i]]);
    if (ssw == 0) begin
      r.f_value = F_FLAT;
      r.status = STATUS_FLAT;
      return r;
    end
    num = ssb * 128'(n_all - p) * 128'd65536;
    den = ssw * 128'(p - 1);
    q = num / den;
    r.f_value = (q >> 32) != 0 ? 32'hFFFF_FFFF : q[31:0];
    r.status = STATUS_OK;
    return r;
  endfunction

  task automatic send_sample(input logic signed [31:0] s, input logic [3:0] g, input bit l);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.group  <= g;
    in_ch.last   <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (row_len < MAX_SAMPLES) begin
      row_samples[row_len] = s;
      row_tags[row_len] = g;
      row_len++;
    end
    if (l) begin
      f_expected.push_back(anova_f(groups_in_use));
      row_len = 0;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (f_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_groups(input logic [4:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    groups_in_use = v < GT_MIN ? 2 : (v > GT_MAX ? 16 : int'(v));
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return $signed(32'($urandom_range(8191, 0))) - 4096;
      2: return $signed(32'($urandom_range(200, 0) << 16)) - (100 << 16);
      default: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  // a row: every group filled if len allows and no stray tag hits, size small mostly
  task automatic send_row(input int len, input bit stray);
    int g;
    for (int i = 0; i < len; i++) begin
      g = i < groups_in_use ? i : $urandom_range(groups_in_use - 1, 0);
      if (stray && $urandom_range(7, 0) == 0) g = $urandom_range(15, 0);
      send_sample(rand_value(), 4'(g), i == len - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= 3000;
    end else if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= $urandom_range(99, 0) >= recv_stall_pct;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (f_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result f=%h st=%0d",
                                       out_ch.f_value, out_ch.status);
      end else begin
        f_result_t e;
        e = f_expected.pop_front();
        if (e.f_value !== out_ch.f_value || e.status !== out_ch.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp f=%h st=%0d got f=%h st=%0d",
                     e.f_value, e.status, out_ch.f_value, out_ch.status);
        end
      end
    end
  end

  task automatic test_directed();
    set_groups(5'd2);
    send_sample(32'sh7FFF_FFFF, 4'd0, 0);
    send_sample(32'sh8000_0000, 4'd1, 0);
    send_sample(32'sh0001_0000, 4'd1, 1);
    send_sample(32'sd5, 4'd0, 0);
    send_sample(32'sd5, 4'd1, 1);
    send_sample(32'sd3, 4'd0, 0);
    send_sample(32'sd3, 4'd0, 0);
    send_sample(32'sd7, 4'd1, 0);
    send_sample(32'sd7, 4'd1, 1);
    send_sample(32'sd1, 4'd0, 0);
    send_sample(32'sd9, 4'd15, 1);
    send_sample(32'sd1, 4'd0, 0);
    send_sample(32'sd2, 4'd0, 0);
    send_sample(32'sd3, 4'd1, 0);
    send_sample(-32'sd4, 4'd15, 0);
    send_sample(32'sd50, 4'd1, 1);
    send_sample(32'sd0, 4'd0, 1);
    // groups far apart with tiny spread saturate
    send_sample(32'sh4000_0000, 4'd0, 0);
    send_sample(32'sh4000_0001, 4'd0, 0);
    send_sample(-32'sh4000_0000, 4'd1, 0);
    send_sample(-32'sh4000_0001, 4'd1, 1);
  endtask

  task automatic test_overflow_row();
    for (int i = 0; i < 70; i++)
      send_sample(rand_value(), 4'($urandom_range(1, 0) ? i % 2 : $urandom_range(15, 0)),
                  i == 69);
    send_row(MAX_SAMPLES, 1);
  endtask

  task automatic test_config_extremes();
    set_groups(5'd0);
    send_row(6, 0);
    set_groups(5'd31);
    send_row(20, 0);
    send_row(40, 1);
    set_groups(5'd16);
    send_row(17, 0);
    set_groups(5'd1);
    send_row(3, 0);
  endtask

  task automatic test_random(input int n_items);
    int sent = 0;
    int len;
    while (sent < n_items) begin
      if ($urandom_range(9, 0) == 0) begin
        len = $urandom_range(groups_in_use + 1, 1);
        for (int i = 0; i < len; i++)
          send_sample(rand_value(), 4'($urandom_range(15, 0)), i == len - 1);
      end else begin
        len = $urandom_range(10, 0) == 0 ? $urandom_range(MAX_SAMPLES, 2)
                                          : $urandom_range(groups_in_use + 8, groups_in_use);
        send_row(len, 1);
      end
      sent += len;
    end
  endtask

  task automatic test_pressure();
    in_ch.valid <= 1'b0;
    hold_off <= 1'b1;
    @(posedge clk);
    hold_off <= 1'b0;
    send_row(4, 0);
    send_row(4, 0);
    send_row(4, 0);
    drain();
    send_row(5, 0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.group = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    row_len = 0;
    groups_in_use = 2;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow_row();
    test_config_extremes();
    test_pressure();
    set_groups(5'd3);
    test_random(250);
    send_idle_pct = 71;
    set_groups(5'd8);
    test_random(250);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    set_groups(5'd2);
    test_random(250);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    set_groups(5'd4);
    test_random(250);
    drain();
    if (mismatches == 0 && f_expected.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
